// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the register allocator RTL.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define RAS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define RAS_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define RAS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define RAS_ASSERT(lbl, clk, rst, prop, msg)
`define RAS_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define RAS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ----- rtl/core/ras_pkg.sv -----
// Shared constants, types and helpers of the register allocator.
// No dependencies; imported by every module and interface of the block.
package ras_pkg;

   localparam int NUM_ALLOC_REGS = 9;
   localparam int SPILL_DEPTH    = 512;
   localparam int AGE_BITS       = 16;

   localparam int GRANT_W = 4;
   localparam int IDX_W   = $clog2(NUM_ALLOC_REGS);
   localparam int SP_AW   = $clog2(SPILL_DEPTH);
   localparam int DEPTH_W = $clog2(SPILL_DEPTH + 1);

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   typedef enum logic [1:0] {
      ERR_OK       = 2'd0,
      ERR_OVERFLOW = 2'd1,
      ERR_POP      = 2'd2
   } ras_err_type;

   typedef struct packed {
      logic [GRANT_W-1:0] granted_reg;
      logic               push_needed;
      logic               pop_needed;
      logic [1:0]         error_code;
   } ras_rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_req;
      logic exec;
      logic scan;
      logic victim;
      logic pop_chk;
      logic load_rsp;
   } ras_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_alloc;
      logic found;
      logic in_range;
      logic pop_go;
      logic scan_last;
   } ras_status_type;

   function automatic logic [AGE_BITS-1:0] age_inc(input logic [AGE_BITS-1:0] age);
      logic [AGE_BITS-1:0] result;
      result = (age == {AGE_BITS{1'b1}}) ? age : age + 1'b1;
      return result;
   endfunction

endpackage

// ----- rtl/core/ras_req_if.sv -----
// Request channel of the register allocator: valid/ready plus command fields.
// Depends on ras_pkg.
interface ras_req_if import ras_pkg::*;;
   logic               valid;
   logic               ready;
   logic               cmd;
   logic [GRANT_W-1:0] free_reg;

   modport source (output valid, output cmd, output free_reg, input ready);
   modport sink (input valid, input cmd, input free_reg, output ready);
endinterface

// ----- rtl/core/ras_rsp_if.sv -----
// Response channel of the register allocator: valid/ready plus result fields.
// Depends on ras_pkg.
interface ras_rsp_if import ras_pkg::*;;
   logic               valid;
   logic               ready;
   logic [GRANT_W-1:0] granted_reg;
   logic               push_needed;
   logic               pop_needed;
   logic [1:0]         error_code;

   modport source (output valid, output granted_reg, output push_needed,
                   output pop_needed, output error_code, input ready);
   modport sink (input valid, input granted_reg, input push_needed,
                 input pop_needed, input error_code, output ready);
endinterface

// ----- rtl/core/ras_ctrl.sv -----
// Controller state machine of the register allocator.
// Depends on ras_pkg; drives the datapath ras_dp through command signals.
module ras_ctrl import ras_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  ras_status_type status,
   output ras_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_VICTIM,
      ST_POP,
      ST_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      cmd.load_req = (state_ff == ST_IDLE) && req_valid;
      cmd.exec     = (state_ff == ST_EXEC);
      cmd.scan     = (state_ff == ST_SCAN);
      cmd.victim   = (state_ff == ST_VICTIM);
      cmd.pop_chk  = (state_ff == ST_POP);
      cmd.load_rsp = (state_ff == ST_RESP) && out_free;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (status.is_alloc && !status.found) begin
               state_in = ST_SCAN;
            end else if (!status.is_alloc && status.in_range && status.pop_go) begin
               state_in = ST_POP;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_SCAN: begin
            if (status.scan_last) state_in = ST_VICTIM;
         end
         ST_VICTIM: state_in = ST_RESP;
         ST_POP:    state_in = ST_RESP;
         ST_RESP: begin
            if (out_free) state_in = ST_IDLE;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- rtl/core/ras_dp.sv -----
// Datapath of the register allocator: flags, ages, spill stack and results.
// Depends on ras_pkg and assert_macros.svh; commanded by ras_ctrl.
`include "assert_macros.svh"

module ras_dp import ras_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  ras_cmd_type        cmd,
   output ras_status_type     status,
   input  logic               req_cmd,
   input  logic [GRANT_W-1:0] req_free_reg,
   output ras_rsp_type        rsp_data
);

   logic [NUM_ALLOC_REGS-1:0] busy_ff, busy_in;
   logic [NUM_ALLOC_REGS-1:0] spilled_ff, spilled_in;
   logic [AGE_BITS-1:0]       age_ff [NUM_ALLOC_REGS];
   logic [AGE_BITS-1:0]       age_in [NUM_ALLOC_REGS];
   logic [DEPTH_W-1:0]        depth_ff, depth_in;

   logic                      cmd_ff;
   logic [GRANT_W-1:0]        free_ff;
   logic [IDX_W-1:0]          scan_idx_ff, scan_idx_in;
   logic [IDX_W-1:0]          best_idx_ff, best_idx_in;
   logic [AGE_BITS-1:0]       best_age_ff, best_age_in;
   ras_rsp_type               res_ff, res_in;
   ras_rsp_type               rsp_ff;

   logic [GRANT_W-1:0]        stack_mem [SPILL_DEPTH];
   logic [GRANT_W-1:0]        rd_data_ff;

   logic [NUM_ALLOC_REGS-1:0] free_vec, lowest_oh, below_mask;
   logic [IDX_W-1:0]          found_idx;
   logic [IDX_W-1:0]          free_idx;
   logic                      found, in_range, pop_go, room;
   logic [AGE_BITS-1:0]       scan_age;

   // The lowest free register as a one-hot; the mask below it covers the
   // registers that age on this allocate, and wraps to all ones when none is free.
   assign free_vec   = ~busy_ff;
   assign lowest_oh  = free_vec & (~free_vec + 1'b1);
   assign below_mask = lowest_oh - 1'b1;
   assign found      = |free_vec;

   always_comb begin
      found_idx = '0;
      for (int i = 0; i < NUM_ALLOC_REGS; i++) begin
         if (lowest_oh[i]) found_idx = IDX_W'(i);
      end
   end

   assign in_range = int'(free_ff) < NUM_ALLOC_REGS;
   assign free_idx = IDX_W'(free_ff);
   assign pop_go   = spilled_ff[free_idx] && (depth_ff != '0);
   assign room     = depth_ff < DEPTH_W'(SPILL_DEPTH);
   assign scan_age = age_ff[scan_idx_ff];

   always_comb begin
      status           = '0;
      status.is_alloc  = (cmd_ff == CMD_ALLOC);
      status.found     = found;
      status.in_range  = in_range;
      status.pop_go    = pop_go;
      status.scan_last = (scan_idx_ff == IDX_W'(NUM_ALLOC_REGS - 1));
   end

   always_comb begin
      busy_in     = busy_ff;
      spilled_in  = spilled_ff;
      age_in      = age_ff;
      depth_in    = depth_ff;
      scan_idx_in = scan_idx_ff;
      best_idx_in = best_idx_ff;
      best_age_in = best_age_ff;
      res_in      = res_ff;

      if (cmd.exec) begin
         res_in = '0;
         if (cmd_ff == CMD_ALLOC) begin
            for (int i = 0; i < NUM_ALLOC_REGS; i++) begin
               if (below_mask[i]) age_in[i] = age_inc(age_ff[i]);
            end
            if (found) begin
               busy_in[found_idx] = 1'b1;
               age_in[found_idx]  = '0;
               res_in.granted_reg = GRANT_W'(found_idx);
            end else begin
               // Every age has just gone up, so the first candidate's age is too.
               scan_idx_in = IDX_W'(1);
               best_idx_in = '0;
               best_age_in = age_inc(age_ff[0]);
            end
         end else if (in_range) begin
            busy_in[free_idx]    = 1'b0;
            spilled_in[free_idx] = 1'b0;
            age_in[free_idx]     = '0;
            if (pop_go) begin
               depth_in = depth_ff - 1'b1;
            end else if (spilled_ff[free_idx]) begin
               res_in.error_code = ERR_POP;
            end
         end
      end

      if (cmd.scan) begin
         if (scan_age > best_age_ff) begin
            best_idx_in = scan_idx_ff;
            best_age_in = scan_age;
         end
         scan_idx_in = scan_idx_ff + 1'b1;
      end

      if (cmd.victim) begin
         spilled_in[best_idx_ff] = 1'b1;
         age_in[best_idx_ff]     = age_inc(best_age_ff);
         res_in                  = '0;
         res_in.granted_reg      = GRANT_W'(best_idx_ff);
         res_in.push_needed      = 1'b1;
         if (room) begin
            depth_in = depth_ff + 1'b1;
         end else begin
            res_in.error_code = ERR_OVERFLOW;
         end
      end

      if (cmd.pop_chk) begin
         res_in            = '0;
         res_in.pop_needed = 1'b1;
         if (rd_data_ff != free_ff) res_in.error_code = ERR_POP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= '0;
         spilled_ff <= '0;
         depth_ff   <= '0;
         for (int i = 0; i < NUM_ALLOC_REGS; i++) begin
            age_ff[i] <= '0;
         end
      end else begin
         busy_ff    <= busy_in;
         spilled_ff <= spilled_in;
         depth_ff   <= depth_in;
         age_ff     <= age_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         cmd_ff  <= req_cmd;
         free_ff <= req_free_reg;
      end
      scan_idx_ff <= scan_idx_in;
      best_idx_ff <= best_idx_in;
      best_age_ff <= best_age_in;
      res_ff      <= res_in;
      if (cmd.load_rsp) rsp_ff <= res_ff;
   end

   // Spill stack: pushed at the current depth, read one below it at every execute step.
   always_ff @(posedge clock) begin
      if (cmd.victim && room) stack_mem[SP_AW'(depth_ff)] <= GRANT_W'(best_idx_ff);
      if (cmd.exec) rd_data_ff <= stack_mem[SP_AW'(depth_ff - 1'b1)];
   end

   assign rsp_data = rsp_ff;

   `RAS_ASSERT(a_depth_bound, clock, reset, depth_ff <= DEPTH_W'(SPILL_DEPTH), "spill depth out of range")
   `RAS_ASSERT(a_spilled_busy, clock, reset, (spilled_ff & ~busy_ff) == '0, "spilled register not busy")
   `RAS_ASSERT_NEXT(a_push_grows, clock, reset, cmd.victim && room, depth_ff == $past(depth_ff) + 1'b1, "push did not grow the stack")
   `RAS_ASSERT_NEXT(a_pop_shrinks, clock, reset, cmd.exec && !status.is_alloc && in_range && pop_go, depth_ff == $past(depth_ff) - 1'b1, "pop did not shrink the stack")

endmodule

// ----- rtl/core/register_allocator_oldest_spill.sv -----
// Register allocator with oldest-victim spill. One request at a time: an allocate that finds a
// free register or a free that needs no pop passes through the execute and response steps,
// a free that pops the spill stack adds a pop step for the registered stack read, and an
// allocate that must spill adds the victim search, which compares one register age per
// cycle, and the victim step. A new request is accepted once the previous response is
// staged, even while it waits on rsp ready.
// Depends on ras_pkg, ras_req_if, ras_rsp_if, ras_ctrl and ras_dp.
module register_allocator_oldest_spill import ras_pkg::*; (
   input logic       clock,
   input logic       reset,
   ras_req_if.sink   req_chan,
   ras_rsp_if.source rsp_chan
);

   ras_cmd_type    cmd;
   ras_status_type status;
   ras_rsp_type    rsp_data;

   ras_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   ras_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_cmd      (req_chan.cmd),
      .req_free_reg (req_chan.free_reg),
      .rsp_data     (rsp_data)
   );

   assign rsp_chan.granted_reg = rsp_data.granted_reg;
   assign rsp_chan.push_needed = rsp_data.push_needed;
   assign rsp_chan.pop_needed  = rsp_data.pop_needed;
   assign rsp_chan.error_code  = rsp_data.error_code;

endmodule

// ----- tb/tb_register_allocator_oldest_spill.sv -----
// Self-checking testbench of register_allocator_oldest_spill: allocate and free requests
// with random gaps and stalls, checked against a predictor that runs in the testbench.
// Depends on ras_pkg, ras_req_if, ras_rsp_if and the allocator RTL.
module tb_register_allocator_oldest_spill;
   import ras_pkg::*;

   typedef struct packed {
      logic               op;
      logic [GRANT_W-1:0] reg_idx;
   } alloc_req_type;

   logic clock;
   logic reset;

   ras_req_if req_if();
   ras_rsp_if rsp_if();

   register_allocator_oldest_spill DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // Predicted allocator state.
   logic                busy_q    [NUM_ALLOC_REGS];
   logic                spilled_q [NUM_ALLOC_REGS];
   logic [AGE_BITS-1:0] age_q     [NUM_ALLOC_REGS];
   logic [GRANT_W-1:0]  spill_lifo [SPILL_DEPTH];
   int unsigned         lifo_depth;

   alloc_req_type alloc_reqs[$];
   alloc_req_type next_req;
   ras_rsp_type   outcome_q[$];
   ras_rsp_type   want;

   int unsigned total_reqs;
   int unsigned accepted_reqs;
   int unsigned mismatches;
   int unsigned send_gap;
   int unsigned stall_left;
   logic        req_taken;
   logic        quiet;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [AGE_BITS-1:0] sat_inc(input logic [AGE_BITS-1:0] a);
      return (&a) ? a : a + 1'b1;
   endfunction

   // Applies one request to the predicted state and returns the response it must produce.
   function automatic ras_rsp_type allocator_outcome(input logic op,
                                                     input logic [GRANT_W-1:0] reg_idx);
      ras_rsp_type r;
      int          victim;
      bit          found;
      r = '0;
      r.error_code = ERR_OK;
      found = 1'b0;
      if (op == CMD_ALLOC) begin
         for (int i = 0; i < NUM_ALLOC_REGS && !found; i++) begin
            if (!busy_q[i]) begin
               busy_q[i] = 1'b1;
               age_q[i] = '0;
               r.granted_reg = i[GRANT_W-1:0];
               found = 1'b1;
            end else begin
               age_q[i] = sat_inc(age_q[i]);
            end
         end
         if (!found) begin
            victim = 0;
            for (int i = 1; i < NUM_ALLOC_REGS; i++) begin
               if (age_q[i] > age_q[victim]) victim = i;
            end
            spilled_q[victim] = 1'b1;
            age_q[victim] = sat_inc(age_q[victim]);
            if (lifo_depth < SPILL_DEPTH) begin
               spill_lifo[SP_AW'(lifo_depth)] = victim[GRANT_W-1:0];
               lifo_depth++;
            end else begin
               r.error_code = ERR_OVERFLOW;
            end
            r.push_needed = 1'b1;
            r.granted_reg = victim[GRANT_W-1:0];
         end
      end else if (reg_idx < NUM_ALLOC_REGS) begin
         if (spilled_q[reg_idx]) begin
            if (lifo_depth == 0) begin
               r.error_code = ERR_POP;
            end else begin
               lifo_depth--;
               if (spill_lifo[SP_AW'(lifo_depth)] != reg_idx) r.error_code = ERR_POP;
               r.pop_needed = 1'b1;
            end
         end
         busy_q[reg_idx] = 1'b0;
         spilled_q[reg_idx] = 1'b0;
         age_q[reg_idx] = '0;
      end
      return r;
   endfunction

   // Mostly no wait, sometimes a few cycles, now and then a long one.
   function automatic int unsigned idle_len();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic push_req(input logic op, input int unsigned reg_idx);
      alloc_req_type item;
      item.op = op;
      item.reg_idx = GRANT_W'(reg_idx);
      alloc_reqs.push_back(item);
   endtask

   // A run of allocates and frees; the allocate share differs from run to run so that
   // the register file sometimes fills up and spills and sometimes drains.
   task automatic mixed_run(input int unsigned count);
      int unsigned alloc_pct;
      alloc_pct = $urandom_range(25, 85);
      for (int unsigned n = 0; n < count; n++) begin
         if ($urandom_range(0, 99) < alloc_pct) begin
            push_req(CMD_ALLOC, $urandom_range(0, 15));
         end else if ($urandom_range(0, 9) == 0) begin
            push_req(CMD_FREE, $urandom_range(NUM_ALLOC_REGS, 15));
         end else begin
            push_req(CMD_FREE, $urandom_range(0, NUM_ALLOC_REGS - 1));
         end
      end
   endtask

   // Acceptance, prediction and response checking, all sampled at the rising edge.
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (outcome_q.size() == 0) begin
               if (mismatches < 10) begin
                  $display("unexpected response: grant=%0d push=%0b pop=%0b err=%0d",
                           rsp_if.granted_reg, rsp_if.push_needed, rsp_if.pop_needed,
                           rsp_if.error_code);
               end
               mismatches++;
            end else begin
               want = outcome_q.pop_front();
               if (rsp_if.granted_reg !== want.granted_reg ||
                   rsp_if.push_needed !== want.push_needed ||
                   rsp_if.pop_needed !== want.pop_needed ||
                   rsp_if.error_code !== want.error_code) begin
                  if (mismatches < 10) begin
                     $display("mismatch: expected grant=%0d push=%0b pop=%0b err=%0d",
                              want.granted_reg, want.push_needed, want.pop_needed,
                              want.error_code);
                     $display("          actual   grant=%0d push=%0b pop=%0b err=%0d",
                              rsp_if.granted_reg, rsp_if.push_needed, rsp_if.pop_needed,
                              rsp_if.error_code);
                  end
                  mismatches++;
               end
            end
         end
         if (req_if.valid && req_if.ready) begin
            outcome_q.push_back(allocator_outcome(req_if.cmd, req_if.free_reg));
            accepted_reqs++;
            if ($urandom_range(0, 99) == 0) quiet <= !quiet;
         end
         req_taken <= req_if.valid && req_if.ready;
      end
   end

   // Request driver: a request stays up until it is taken, then an optional gap follows.
   always @(negedge clock) begin
      if (!reset) begin
         if (req_if.valid && !req_taken) begin
            // Still waiting for the allocator to take the current request.
         end else if (send_gap != 0) begin
            req_if.valid <= 1'b0;
            send_gap <= send_gap - 1;
         end else if (alloc_reqs.size() != 0) begin
            next_req = alloc_reqs.pop_front();
            req_if.valid <= 1'b1;
            req_if.cmd <= next_req.op;
            req_if.free_reg <= next_req.reg_idx;
            send_gap <= quiet ? 0 : idle_len();
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Response back-pressure.
   always @(negedge clock) begin
      if (!reset) begin
         if (stall_left != 0) begin
            rsp_if.ready <= 1'b0;
            stall_left <= stall_left - 1;
         end else begin
            rsp_if.ready <= 1'b1;
            if (!quiet && $urandom_range(0, 3) == 0) stall_left <= idle_len();
         end
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.cmd = CMD_ALLOC;
      req_if.free_reg = '0;
      rsp_if.ready = 1'b0;
      req_taken = 1'b0;
      quiet = 1'b0;
      send_gap = 0;
      stall_left = 0;
      accepted_reqs = 0;
      mismatches = 0;
      lifo_depth = 0;
      for (int i = 0; i < NUM_ALLOC_REGS; i++) begin
         busy_q[i] = 1'b0;
         spilled_q[i] = 1'b0;
         age_q[i] = '0;
      end

      // Frees of an idle register and of indexes past the register file.
      push_req(CMD_FREE, 0);
      push_req(CMD_FREE, 15);
      push_req(CMD_FREE, NUM_ALLOC_REGS);
      // Fill every register, then spill the oldest one twice in a row.
      repeat (NUM_ALLOC_REGS) push_req(CMD_ALLOC, $urandom_range(0, 15));
      push_req(CMD_ALLOC, 15);
      push_req(CMD_ALLOC, 0);
      // Free the spilled register (pops), free it again (no pop), then reuse it.
      push_req(CMD_FREE, 0);
      push_req(CMD_FREE, 0);
      push_req(CMD_ALLOC, 0);
      push_req(CMD_FREE, 8);
      push_req(CMD_FREE, 4);
      push_req(CMD_ALLOC, 15);
      push_req(CMD_ALLOC, 0);
      push_req(CMD_ALLOC, 15);
      push_req(CMD_FREE, 1);
      push_req(CMD_FREE, 8);

      repeat (8) mixed_run($urandom_range(15, 35));
      // A long run of allocates drives the spill stack past full.
      repeat (SPILL_DEPTH + 18) push_req(CMD_ALLOC, $urandom_range(0, 15));
      repeat (8) mixed_run($urandom_range(15, 35));
      total_reqs = alloc_reqs.size();

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (!(accepted_reqs == total_reqs && outcome_q.size() == 0)) @(negedge clock);
      repeat (20) @(negedge clock);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
